// File: rtl/core/signed_int_to_decimal_text_assert.svh
// assertion macros used by the checker file
`ifndef SIGNED_INT_TO_DECIMAL_TEXT_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_TEXT_ASSERT_SVH

// checked only while out of reset
`define S2TD_ASSERT(name, expr) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) expr) \
        else $error("s2td assertion failed");

// checked at every edge, reset included
`define S2TD_ASSERT_ALWAYS(name, expr) \
    name: assert property (@(posedge aclk) expr) \
        else $error("s2td assertion failed during or after reset");

`endif

// File: rtl/core/s2td_pkg.sv
// ----------------------------------------------------------------------------
// s2td_pkg
// shared widths, character codes and the converter to emitter hand-off type
// ----------------------------------------------------------------------------
package s2td_pkg;

    localparam int VALUE_WIDTH = 32;

    // decimal digits of the largest magnitude, 2^(VALUE_WIDTH-1)
    function automatic int digits_of_max();
        longint unsigned v;
        int n;
        v = 64'd1 << (VALUE_WIDTH - 1);
        n = 0;
        while (v != 64'd0) begin
            v = v / 10;
            n = n + 1;
        end
        return n;
    endfunction

    localparam int NUM_DIGITS = digits_of_max();
    localparam int BCD_WIDTH  = 4 * NUM_DIGITS;
    localparam int CNT_WIDTH  = $clog2(VALUE_WIDTH + 1);
    localparam int REM_WIDTH  = $clog2(NUM_DIGITS + 1);

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    typedef struct packed {
        logic                 negative;
        logic [BCD_WIDTH-1:0] bcd;
    } s2td_conv_t;

endpackage

// File: rtl/core/s2td_dabble.sv
// ----------------------------------------------------------------------------
// s2td_dabble
// bit-serial binary to bcd conversion by shift and add-3, msb first
// ----------------------------------------------------------------------------
module s2td_dabble (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [s2td_pkg::VALUE_WIDTH-1:0] in_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output s2td_pkg::s2td_conv_t                out_conv
);
    import s2td_pkg::*;

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_RUN  = 3'b010,
        C_DONE = 3'b100
    } conv_state_t;

    conv_state_t            state_reg, state_next;
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic [BCD_WIDTH-1:0]   bcd_reg, bcd_next;
    logic [CNT_WIDTH-1:0]   cnt_reg, cnt_next;
    logic                   neg_reg, neg_next;
    logic [BCD_WIDTH-1:0]   adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        logic [3:0] dig;
        dig = 4'd0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            dig = bcd_reg[4*i +: 4];
            adj[4*i +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
        end
    end

    always_comb begin
        state_next = state_reg;
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        case (state_reg)
            C_IDLE: begin
                if (in_valid) begin
                    neg_next   = in_value[VALUE_WIDTH-1];
                    mag_next   = in_value[VALUE_WIDTH-1] ?
                                 (~in_value) + VALUE_WIDTH'(1) : in_value;
                    bcd_next   = '0;
                    cnt_next   = CNT_WIDTH'(VALUE_WIDTH);
                    state_next = C_RUN;
                end
            end
            C_RUN: begin
                bcd_next = {adj[BCD_WIDTH-2:0], mag_reg[VALUE_WIDTH-1]};
                mag_next = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_WIDTH'(1);
                if (cnt_reg == CNT_WIDTH'(1)) begin
                    state_next = C_DONE;
                end
            end
            C_DONE: begin
                if (out_ready) begin
                    state_next = C_IDLE;
                end
            end
            default: begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

    assign in_ready          = (state_reg == C_IDLE);
    assign out_valid         = (state_reg == C_DONE);
    assign out_conv.negative = neg_reg;
    assign out_conv.bcd      = bcd_reg;

endmodule

// File: rtl/core/s2td_emit.sv
// ----------------------------------------------------------------------------
// s2td_emit
// digit shifter: drops leading zeros, then, while m_ready is high, sends sign and digits one a cycle
// ----------------------------------------------------------------------------
module s2td_emit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  s2td_pkg::s2td_conv_t in_conv,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_character,
    output logic                 m_last
);
    import s2td_pkg::*;

    typedef enum logic [2:0] {
        E_IDLE = 3'b001,
        E_SKIP = 3'b010,
        E_OUT  = 3'b100
    } emit_state_t;

    emit_state_t          state_reg, state_next;
    logic [BCD_WIDTH-1:0] digits_reg, digits_next;
    logic [REM_WIDTH-1:0] remain_reg, remain_next;
    logic                 neg_reg, neg_next;
    logic                 valid_reg, valid_next;
    logic [7:0]           char_reg, char_next;
    logic                 last_reg, last_next;
    logic [3:0]           top_digit;
    logic                 slot_free;

    assign top_digit = digits_reg[BCD_WIDTH-1 -: 4];
    assign slot_free = !valid_reg || m_ready;

    always_comb begin
        state_next  = state_reg;
        digits_next = digits_reg;
        remain_next = remain_reg;
        neg_next    = neg_reg;
        valid_next  = valid_reg && !m_ready;
        char_next   = char_reg;
        last_next   = last_reg;
        case (state_reg)
            E_IDLE: begin
                if (in_valid) begin
                    digits_next = in_conv.bcd;
                    neg_next    = in_conv.negative;
                    remain_next = REM_WIDTH'(NUM_DIGITS);
                    state_next  = E_SKIP;
                end
            end
            E_SKIP: begin
                if (top_digit == 4'd0 && remain_reg != REM_WIDTH'(1)) begin
                    digits_next = {digits_reg[BCD_WIDTH-5:0], 4'b0000};
                    remain_next = remain_reg - REM_WIDTH'(1);
                end else begin
                    state_next = E_OUT;
                end
            end
            E_OUT: begin
                if (slot_free) begin
                    valid_next = 1'b1;
                    if (neg_reg) begin
                        char_next = CHAR_MINUS;
                        last_next = 1'b0;
                        neg_next  = 1'b0;
                    end else begin
                        char_next   = CHAR_ZERO + {4'b0000, top_digit};
                        last_next   = (remain_reg == REM_WIDTH'(1));
                        digits_next = {digits_reg[BCD_WIDTH-5:0], 4'b0000};
                        remain_next = remain_reg - REM_WIDTH'(1);
                        if (remain_reg == REM_WIDTH'(1)) begin
                            state_next = E_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        digits_reg <= digits_next;
        remain_reg <= remain_next;
        neg_reg    <= neg_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
    end

    assign in_ready    = (state_reg == E_IDLE);
    assign m_valid     = valid_reg;
    assign m_character = char_reg;
    assign m_last      = last_reg;

endmodule

// File: rtl/core/signed_int_to_decimal_text.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_text
// signed integer to ascii decimal text, one character per output word
// ----------------------------------------------------------------------------
// Each word taken on s_ is a two's complement integer; its decimal text leaves
// on m_ one character per word, most significant first, with a leading '-'
// for negative values, no leading zeros, a single '0' for zero and m_last
// high on the final character. The converter takes a word, then runs its
// shift-and-add-3 loop over VALUE_WIDTH (32 by default) magnitude bits, one
// bit per cycle; s_ready comes back only once the emitter has taken the
// result. The emitter then drops leading zeros at one digit a cycle and
// sends one character per cycle while m_ is ready. Emission of one number
// overlaps conversion of the next, so the steady rate is set by the longer
// of the two and by stalls on the output side.
module signed_int_to_decimal_text (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [s2td_pkg::VALUE_WIDTH-1:0] s_value,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [7:0]                              m_character,
    output logic                                    m_last
);
    import s2td_pkg::*;

    // hand-off between converter and emitter
    logic       conv_valid;
    logic       conv_ready;
    s2td_conv_t conv_data;

    // bit-serial conversion to packed bcd, holds the result until taken
    s2td_dabble u_dabble (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_value  (s_value),
        .out_valid (conv_valid),
        .out_ready (conv_ready),
        .out_conv  (conv_data)
    );

    // digit shifter with the output word register
    s2td_emit u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (conv_valid),
        .in_ready    (conv_ready),
        .in_conv     (conv_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

endmodule

// File: rtl/core/s2td_checker.sv
// ----------------------------------------------------------------------------
// s2td_checker
// port-level checks on the text output, bound to the top level
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_text_assert.svh"

module s2td_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_character,
    input logic       m_last
);
    import s2td_pkg::*;

    // nothing on the output straight after reset
    `S2TD_ASSERT_ALWAYS(a_idle_after_reset, !aresetn |=> !m_valid)

    // a stalled output word holds
    `S2TD_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_character) && $stable(m_last))

    // only '-' or a digit ever leaves
    `S2TD_ASSERT(a_char_set, m_valid |-> (m_character == CHAR_MINUS) || (m_character >= CHAR_ZERO && m_character <= CHAR_ZERO + 8'd9))

    // a sign never ends the text
    `S2TD_ASSERT(a_sign_not_last, m_valid && m_character == CHAR_MINUS |-> !m_last)

    // one word at a time through the converter
    `S2TD_ASSERT(a_one_at_a_time, s_valid && s_ready |=> !s_ready)

endmodule

bind signed_int_to_decimal_text s2td_checker u_s2td_checker (.*);
